>>> sv/nts_pkg.sv
package nts_pkg;

   localparam int TABLE_DEPTH = 16384;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int OUT_IDX_W   = 14;
   localparam int STAMP_W     = 32;
   localparam int WORD_W      = 32;

   // request kinds
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_APPENDED = 3'd0;
   localparam logic [2:0] ST_DROPPED  = 3'd1;
   localparam logic [2:0] ST_ANSWERED = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_APPEND,
      OP_CLEAR,
      OP_EMPTY,
      OP_PROBE,
      OP_STEP,
      OP_READ_ZERO,
      OP_READ_NEXT,
      OP_RESP_RD,
      OP_RESP_NEAR,
      OP_RESP_BELOW
   } op_type;

   typedef struct packed {
      logic   capture;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       empty;
      logic       hit;
      logic       step_ends;
      logic       below_valid;
      logic       has_next;
   } stat_type;

endpackage

>>> sv/nts_ram.sv
module nts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/nts_ctrl.sv
module nts_ctrl
   import nts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DISPATCH  = 7'b0000010,
      S_PROBE     = 7'b0000100,
      S_COMPARE   = 7'b0001000,
      S_FINISH    = 7'b0010000,
      S_WAIT_RD   = 7'b0100000,
      S_WAIT_NEXT = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            case (stat.kind)
               REQ_APPEND: cmd.op = OP_APPEND;
               REQ_CLEAR:  cmd.op = OP_CLEAR;
               REQ_QUERY: begin
                  if (stat.empty) begin
                     cmd.op = OP_EMPTY;
                  end else begin
                     state_in = S_PROBE;
                  end
               end
               default: cmd.op = OP_NONE;
            endcase
         end
         S_PROBE: begin
            cmd.op   = OP_PROBE;
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            if (stat.hit) begin
               cmd.op   = OP_RESP_RD;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_STEP;
               state_in = stat.step_ends ? S_FINISH : S_PROBE;
            end
         end
         S_FINISH: begin
            if (!stat.below_valid) begin
               cmd.op   = OP_READ_ZERO;
               state_in = S_WAIT_RD;
            end else if (stat.has_next) begin
               cmd.op   = OP_READ_NEXT;
               state_in = S_WAIT_NEXT;
            end else begin
               cmd.op   = OP_RESP_BELOW;
               state_in = S_IDLE;
            end
         end
         S_WAIT_RD: begin
            cmd.op   = OP_RESP_RD;
            state_in = S_IDLE;
         end
         S_WAIT_NEXT: begin
            cmd.op   = OP_RESP_NEAR;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_compare_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMPARE |-> $past(state_ff) == S_PROBE)
      else $error("compare state entered without a probe");

   a_accept_dispatches: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_DISPATCH)
      else $error("accepted request not dispatched");

   a_next_needs_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT_NEXT |-> stat.below_valid)
      else $error("neighbor compare without a lower entry");

endmodule

>>> sv/nts_dp.sv
module nts_dp
   import nts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [1:0]           req_type,
   input  logic [STAMP_W-1:0]   req_stamp,
   input  logic [WORD_W-1:0]    req_reading_word,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [OUT_IDX_W-1:0] rsp_found_index,
   output logic [STAMP_W-1:0]   rsp_found_stamp,
   output logic [WORD_W-1:0]    rsp_found_word,
   output logic                 rsp_exact_hit
);

   logic [1:0]           kind_ff;
   logic [STAMP_W-1:0]   target_ff;
   logic [WORD_W-1:0]    word_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     lo_ff;
   logic [CNT_W-1:0]     hi_ff;      // exclusive upper bound
   logic [IDX_W-1:0]     cand_ff;
   logic                 below_valid_ff;
   logic [IDX_W-1:0]     below_idx_ff;
   logic [STAMP_W-1:0]   below_stamp_ff;
   logic [WORD_W-1:0]    below_word_ff;
   logic [STAMP_W-1:0]   below_dist_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [OUT_IDX_W-1:0] rsp_idx_ff;
   logic [STAMP_W-1:0]   rsp_stamp_ff;
   logic [WORD_W-1:0]    rsp_word_ff;
   logic                 rsp_hit_ff;

   logic [CNT_W-1:0]     span;
   logic [CNT_W-1:0]     mid;
   logic [IDX_W-1:0]     next_idx;
   logic [IDX_W-1:0]     rd_addr;
   logic [STAMP_W-1:0]   rd_stamp;
   logic [WORD_W-1:0]    rd_word;
   logic                 wr_en;
   logic                 full;
   logic                 lt;
   logic [STAMP_W-1:0]   next_dist;
   logic                 near_wins;

   assign span      = hi_ff - lo_ff - CNT_W'(1);
   assign mid       = lo_ff + (span >> 1);
   assign next_idx  = below_idx_ff + IDX_W'(1);
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign wr_en     = (cmd.op == OP_APPEND) && !full;
   assign lt        = (rd_stamp < target_ff);
   assign next_dist = (rd_stamp >= target_ff) ? (rd_stamp - target_ff)
                                              : (target_ff - rd_stamp);
   assign near_wins = (next_dist < below_dist_ff);

   always_comb begin
      case (cmd.op)
         OP_READ_ZERO: rd_addr = '0;
         OP_READ_NEXT: rd_addr = next_idx;
         default:      rd_addr = mid[IDX_W-1:0];
      endcase
   end

   nts_ram #(.WIDTH(STAMP_W), .DEPTH(TABLE_DEPTH)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (target_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_stamp)
   );

   nts_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (word_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign stat.kind        = kind_ff;
   assign stat.empty       = (count_ff == '0);
   assign stat.hit         = (rd_stamp == target_ff);
   assign stat.step_ends   = lt ? ((mid + CNT_W'(1)) >= hi_ff) : (mid <= lo_ff);
   assign stat.below_valid = below_valid_ff;
   assign stat.has_next    = below_valid_ff &&
                             ((CNT_W'(below_idx_ff) + CNT_W'(1)) < count_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         lo_ff          <= '0;
         hi_ff          <= '0;
         below_valid_ff <= 1'b0;
         target_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.capture) begin
            target_ff      <= req_stamp;
            lo_ff          <= '0;
            hi_ff          <= count_ff;
            below_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_APPEND: begin
               rsp_valid_ff <= 1'b1;
               if (!full) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            OP_CLEAR: begin
               rsp_valid_ff <= 1'b1;
               count_ff     <= '0;
            end
            OP_EMPTY, OP_RESP_RD, OP_RESP_NEAR, OP_RESP_BELOW: rsp_valid_ff <= 1'b1;
            OP_STEP: begin
               // narrow the window and remember the last entry below target
               if (lt) begin
                  below_valid_ff <= 1'b1;
                  lo_ff          <= mid + CNT_W'(1);
               end else begin
                  hi_ff <= mid;
               end
            end
            default: ;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_type;
         word_ff <= req_reading_word;
      end
      case (cmd.op)
         OP_APPEND: begin
            rsp_status_ff <= full ? ST_DROPPED : ST_APPENDED;
            rsp_idx_ff    <= '0;
            rsp_stamp_ff  <= '0;
            rsp_word_ff   <= '0;
            rsp_hit_ff    <= 1'b0;
         end
         OP_CLEAR, OP_EMPTY: begin
            rsp_status_ff <= (cmd.op == OP_CLEAR) ? ST_CLEARED : ST_EMPTY;
            rsp_idx_ff    <= '0;
            rsp_stamp_ff  <= '0;
            rsp_word_ff   <= '0;
            rsp_hit_ff    <= 1'b0;
         end
         OP_PROBE:     cand_ff <= mid[IDX_W-1:0];
         OP_READ_ZERO: cand_ff <= '0;
         OP_READ_NEXT: cand_ff <= next_idx;
         OP_STEP: begin
            if (lt) begin
               below_idx_ff   <= cand_ff;
               below_stamp_ff <= rd_stamp;
               below_word_ff  <= rd_word;
               below_dist_ff  <= target_ff - rd_stamp;
            end
         end
         OP_RESP_RD: begin
            rsp_status_ff <= ST_ANSWERED;
            rsp_idx_ff    <= OUT_IDX_W'(cand_ff);
            rsp_stamp_ff  <= rd_stamp;
            rsp_word_ff   <= rd_word;
            rsp_hit_ff    <= (rd_stamp == target_ff);
         end
         OP_RESP_NEAR, OP_RESP_BELOW: begin
            rsp_status_ff <= ST_ANSWERED;
            // the successor wins only when strictly closer
            if ((cmd.op == OP_RESP_NEAR) && near_wins) begin
               rsp_idx_ff   <= OUT_IDX_W'(cand_ff);
               rsp_stamp_ff <= rd_stamp;
               rsp_word_ff  <= rd_word;
               rsp_hit_ff   <= (rd_stamp == target_ff);
            end else begin
               rsp_idx_ff   <= OUT_IDX_W'(below_idx_ff);
               rsp_stamp_ff <= below_stamp_ff;
               rsp_word_ff  <= below_word_ff;
               rsp_hit_ff   <= (below_stamp_ff == target_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_idx_ff;
   assign rsp_found_stamp = rsp_stamp_ff;
   assign rsp_found_word  = rsp_word_ff;
   assign rsp_exact_hit   = rsp_hit_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search window inverted");

   a_below_under_target: assert property (@(posedge clock) disable iff (reset)
      below_valid_ff |-> below_stamp_ff < target_ff)
      else $error("lower entry not below target");

endmodule

>>> sv/nearest_timestamp_search_top.sv
// Append, clear and query on an empty table: result strobe registered from the dispatch
// state; a new request is accepted only once the previous result is shown.
// Query: P probes (at most 15 at 16384 entries), then a read of entry 0 or of the
// successor if needed; each probe is an address, then a registered table read.
// busy drops in the cycle the result is shown; the receiver cannot stall.
// Reset clears the entry count and control registers; table contents stay undefined, no clearing pass.
module nearest_timestamp_search_top
   import nts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [STAMP_W-1:0]   req_stamp,
   input  logic [WORD_W-1:0]    req_reading_word,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [OUT_IDX_W-1:0] rsp_found_index,
   output logic [STAMP_W-1:0]   rsp_found_stamp,
   output logic [WORD_W-1:0]    rsp_found_word,
   output logic                 rsp_exact_hit
);

   cmd_type  cmd;
   stat_type stat;

   nts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   nts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_stamp        (req_stamp),
      .req_reading_word (req_reading_word),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_found_index  (rsp_found_index),
      .rsp_found_stamp  (rsp_found_stamp),
      .rsp_found_word   (rsp_found_word),
      .rsp_exact_hit    (rsp_exact_hit)
   );

endmodule
